@@ design/crc32e_pkg.sv @@
// Shared types, constants and lookup function for the MSB-first CRC-32 engine.
package crc32e_pkg;

    localparam int CRC_W        = 32;
    localparam int BYTE_W       = 8;
    localparam int ADDR_W       = 3;
    localparam int BUILD_ROUNDS = 255;
    localparam int CNT_W        = $clog2(BUILD_ROUNDS);

    localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] SEED_LSB   = 32'h0100_0000;

    // Register index taken from paddr[2]
    localparam logic REG_POLYNOMIAL = 1'b0;

    // One basis word per index bit of the byte table
    typedef logic [BYTE_W-1:0][CRC_W-1:0] basis_t;

    // Table entry is linear in its index: xor the basis words that are selected
    function automatic logic [CRC_W-1:0] table_lookup(
        input logic [BYTE_W-1:0] idx,
        input basis_t            basis
    );
        logic [CRC_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (idx[k])
            begin
                acc = acc ^ basis[k];
            end
        end
        return acc;
    endfunction

endpackage

@@ design/crc32_msb_first_byte_engine.sv @@
// Top level of the byte-serial MSB-first CRC-32 engine with programmable polynomial.
//
// Input channel (in_valid/in_ready) carries one message word per transfer:
// data_byte, start_req (reload all ones before the byte) and last (close the
// message). Output channel (out_valid/out_ready) carries crc_value, the
// register xor all ones, one word per message.
// A new input word can be taken every cycle while in_ready is high. The
// checksum is registered into the output stage in the cycle after the last word.
// A two-entry output stage (register plus skid) lets input continue while a
// checksum waits; in_ready drops when both entries are full or during a basis rebuild.
// The polynomial register sits at APB address 0 (pready is always high).
// After reset, and after each polynomial write, the eight table basis words
// are rebuilt by 255 shift steps, one per cycle, with in_ready held low
// throughout. APB writes are taken at any time.
// Reset clears the CRC register to all ones, loads polynomial 0x04C11DB7 and
// empties the output stage.
module crc32_msb_first_byte_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crc32e_pkg::ADDR_W-1:0]   paddr,
    input  logic [crc32e_pkg::CRC_W-1:0]    pwdata,
    output logic [crc32e_pkg::CRC_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [crc32e_pkg::BYTE_W-1:0]   data_byte,
    input  logic                            start_req,
    input  logic                            last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [crc32e_pkg::CRC_W-1:0]    crc_value
);
    import crc32e_pkg::*;

    basis_t           basis;
    logic             basis_busy;
    logic             accept;
    logic             res_push;
    logic [CRC_W-1:0] res_value;
    logic             outq_full;

    assign in_ready = !basis_busy && !outq_full;
    assign accept   = in_valid && in_ready;

    crc32e_basis u_basis (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .basis   (basis),
        .busy    (basis_busy)
    );

    crc32e_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .start_req (start_req),
        .last      (last),
        .basis     (basis),
        .res_push  (res_push),
        .res_value (res_value)
    );

    crc32e_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .value     (res_value),
        .full      (outq_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .crc_value (crc_value)
    );

endmodule

@@ design/crc32e_basis.sv @@
// Polynomial register, APB access and the iterative builder of the table basis words.
module crc32e_basis (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [crc32e_pkg::ADDR_W-1:0]       paddr,
    input  logic [crc32e_pkg::CRC_W-1:0]        pwdata,
    output logic [crc32e_pkg::CRC_W-1:0]        prdata,
    output logic                                pready,
    output crc32e_pkg::basis_t                  basis,
    output logic                                busy
);
    import crc32e_pkg::*;

    typedef enum logic [2:0] {
        BLD_IDLE  = 3'b001,
        BLD_LOAD  = 3'b010,
        BLD_SHIFT = 3'b100
    } bld_state_t;

    bld_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CRC_W-1:0] poly_reg, poly_next;
    basis_t           basis_reg, basis_next;
    logic             poly_write;

    assign pready     = 1'b1;
    assign poly_write = psel && penable && pwrite && (paddr[2] == REG_POLYNOMIAL);
    assign prdata     = (paddr[2] == REG_POLYNOMIAL) ? poly_reg : '0;
    assign basis      = basis_reg;
    assign busy       = (state_reg != BLD_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        poly_next  = poly_reg;
        basis_next = basis_reg;
        case (state_reg)
            BLD_LOAD:
            begin
                for (int k = 0; k < BYTE_W; k++)
                begin
                    basis_next[k] = SEED_LSB << k;
                end
                cnt_next   = '0;
                state_next = BLD_SHIFT;
            end
            BLD_SHIFT:
            begin
                // One shift step on all eight words per cycle
                for (int k = 0; k < BYTE_W; k++)
                begin
                    basis_next[k] = {basis_reg[k][CRC_W-2:0], 1'b0}
                                    ^ (basis_reg[k][CRC_W-1] ? poly_reg : '0);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(BUILD_ROUNDS - 1))
                begin
                    state_next = BLD_IDLE;
                end
            end
            BLD_IDLE:
            begin
                state_next = BLD_IDLE;
            end
            default:
            begin
                state_next = BLD_LOAD;
            end
        endcase
        // A new polynomial restarts the build
        if (poly_write)
        begin
            poly_next  = pwdata;
            state_next = BLD_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BLD_LOAD;
            cnt_reg   <= '0;
            poly_reg  <= POLY_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            poly_reg  <= poly_next;
        end
    end

    always_ff @(posedge clk)
    begin
        basis_reg <= basis_next;
    end

endmodule

@@ design/crc32e_core.sv @@
// CRC register and the byte update through the basis-word lookup.
module crc32e_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [crc32e_pkg::BYTE_W-1:0]   data_byte,
    input  logic                            start_req,
    input  logic                            last,
    input  crc32e_pkg::basis_t              basis,
    output logic                            res_push,
    output logic [crc32e_pkg::CRC_W-1:0]    res_value
);
    import crc32e_pkg::*;

    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [CRC_W-1:0]  crc_base;
    logic [BYTE_W-1:0] idx;
    logic [CRC_W-1:0]  crc_upd;

    assign crc_base = start_req ? ALL_ONES : crc_reg;
    assign idx      = crc_base[CRC_W-1 -: BYTE_W] ^ data_byte;
    assign crc_upd  = table_lookup(idx, basis) ^ {crc_base[CRC_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    assign crc_next = accept ? crc_upd : crc_reg;

    assign res_push  = accept && last;
    assign res_value = crc_upd ^ ALL_ONES;

    // Hold the register after the last word so a following segment can continue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= ALL_ONES;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

endmodule

@@ design/crc32e_outq.sv @@
// Output register with a skid stage for finished checksums.
module crc32e_outq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic [crc32e_pkg::CRC_W-1:0]    value,
    output logic                            full,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [crc32e_pkg::CRC_W-1:0]    crc_value
);
    import crc32e_pkg::*;

    logic             out_valid_reg, out_valid_next;
    logic [CRC_W-1:0] out_value_reg, out_value_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [CRC_W-1:0] skid_value_reg, skid_value_next;
    logic             out_fire;

    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign crc_value = out_value_reg;
    assign full      = skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        skid_valid_next = skid_valid_reg;
        skid_value_next = skid_value_reg;
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        // Advance the skid word into the output slot
        if (skid_valid_reg && out_fire)
        begin
            out_value_next  = skid_value_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (out_valid_next)
            begin
                skid_value_next = value;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_value_next = value;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        skid_value_reg <= skid_value_next;
    end

endmodule
